FILE: sv/ioct_pkg.sv
// Shared constants, types and the controller-to-datapath command bundle
// for the index-of-coincidence tally. No dependencies.
`default_nettype none

package ioct_pkg;

  // Longest string that is counted; later bytes only set the overflow flag.
  localparam int MAX_LEN     = 512;
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int PROD_W      = 2 * CNT_W;

  localparam int NUM_LETTERS = 26;
  localparam int IDX_W       = $clog2(NUM_LETTERS);

  // Field widths of the streams.
  localparam int CHAR_W      = 8;
  localparam int MS_W        = 18;
  localparam int PT_W        = 18;
  localparam int SL_W        = 10;
  localparam int NL_W        = 10;
  localparam int OUT_DATA_W  = MS_W + PT_W + SL_W + NL_W;

  localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LETTERS - 1);

  typedef struct packed {
    logic             count;    // input beat accepted, tally it
    logic             clr_acc;  // start of a reduction pass
    logic             mul_en;   // register n*(n-1) for letter sel
    logic             acc_en;   // add registered product into the sum
    logic             load;     // move result to output, clear tallies
    logic [IDX_W-1:0] sel;      // letter under reduction
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/ioct_dp.sv
// Datapath of the index-of-coincidence tally: letter counters, length and
// non-letter tallies, product/accumulate unit and output register.
// Depends on ioct_pkg.
`default_nettype none

module ioct_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ioct_pkg::cmd_t                 cmd,
  input  wire logic [ioct_pkg::CHAR_W-1:0]    char_code,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [ioct_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_ovf,
  output logic                                out_free
);

  logic [ioct_pkg::CNT_W-1:0]  letter_cnt [ioct_pkg::NUM_LETTERS];
  logic [ioct_pkg::CNT_W-1:0]  byte_count;
  logic [ioct_pkg::CNT_W-1:0]  other_count;
  logic                        overflow_seen;

  logic [ioct_pkg::PROD_W-1:0] prod;
  logic [ioct_pkg::PROD_W-1:0] pair;
  logic [ioct_pkg::MS_W-1:0]   acc;

  logic                        is_upper;
  logic                        is_lower;
  logic                        is_letter;
  logic [ioct_pkg::IDX_W-1:0]  letter_idx;
  logic                        full;
  logic [ioct_pkg::CNT_W-1:0]  sel_cnt;
  logic [ioct_pkg::CNT_W-1:0]  sel_cnt_m1;
  logic [ioct_pkg::CNT_W-1:0]  len_m1;

  always_comb begin
    is_upper   = (char_code >= ioct_pkg::CHAR_UP_A) && (char_code <= ioct_pkg::CHAR_UP_Z);
    is_lower   = (char_code >= ioct_pkg::CHAR_LO_A) && (char_code <= ioct_pkg::CHAR_LO_Z);
    is_letter  = is_upper || is_lower;
    if (is_upper) begin
      letter_idx = ioct_pkg::IDX_W'(char_code - ioct_pkg::CHAR_UP_A);
    end else begin
      letter_idx = ioct_pkg::IDX_W'(char_code - ioct_pkg::CHAR_LO_A);
    end
    full       = (byte_count == ioct_pkg::CNT_W'(ioct_pkg::MAX_LEN));
    sel_cnt    = letter_cnt[cmd.sel];
    sel_cnt_m1 = sel_cnt - 1'b1;   // wraps at zero, product is zero anyway
    len_m1     = byte_count - 1'b1;
  end

  assign out_free = !out_valid || out_ready;

  // Tallies
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      for (int i = 0; i < ioct_pkg::NUM_LETTERS; i++) begin
        letter_cnt[i] <= '0;
      end
      byte_count    <= '0;
      other_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.count) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        byte_count <= byte_count + 1'b1;
        if (is_letter) begin
          for (int i = 0; i < ioct_pkg::NUM_LETTERS; i++) begin
            if (letter_idx == ioct_pkg::IDX_W'(i)) begin
              letter_cnt[i] <= letter_cnt[i] + 1'b1;
            end
          end
        end else begin
          other_count <= other_count + 1'b1;
        end
      end
    end
  end

  // Product / accumulate, one letter per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ioct_pkg::PROD_W'(sel_cnt) * ioct_pkg::PROD_W'(sel_cnt_m1);
      pair <= ioct_pkg::PROD_W'(byte_count) * ioct_pkg::PROD_W'(len_m1);
    end
    if (cmd.clr_acc) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + ioct_pkg::MS_W'(prod);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      out_data <= {ioct_pkg::NL_W'(other_count), ioct_pkg::SL_W'(byte_count),
                   ioct_pkg::PT_W'(pair), acc};
      out_ovf  <= overflow_seen;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= ioct_pkg::CNT_W'(ioct_pkg::MAX_LEN))
    else $error("length tally past limit");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid && (byte_count == '0) && !overflow_seen)
    else $error("load did not present result and clear tallies");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> out_free)
    else $error("result loaded over an untaken beat");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> full)
    else $error("overflow flagged before length saturated");

endmodule

`default_nettype wire

FILE: sv/ioct_ctrl.sv
// Controller of the index-of-coincidence tally: accepts bytes, then steps
// the datapath through the 26-letter reduction and the result hand-off.
// Depends on ioct_pkg.
`default_nettype none

module ioct_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_last,
  input  wire logic        out_free,
  output logic             in_ready,
  output ioct_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_REDUCE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                     state;
  logic [ioct_pkg::IDX_W-1:0] sel;
  logic                       clr_acc;
  logic                       acc_en;
  logic                       beat;

  assign in_ready = (state == ST_ACCUM);
  assign beat     = in_valid && in_ready;

  always_comb begin
    cmd.count   = beat;
    cmd.clr_acc = clr_acc;
    cmd.mul_en  = (state == ST_REDUCE);
    cmd.acc_en  = acc_en;
    cmd.load    = (state == ST_FINISH) && out_free;
    cmd.sel     = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_ACCUM;
      sel     <= '0;
      clr_acc <= 1'b0;
      acc_en  <= 1'b0;
    end else begin
      clr_acc <= 1'b0;
      acc_en  <= (state == ST_REDUCE);
      case (state)
        ST_ACCUM: begin
          if (beat && in_last) begin
            state   <= ST_REDUCE;
            sel     <= '0;
            clr_acc <= 1'b1;
          end
        end
        ST_REDUCE: begin
          if (sel == ioct_pkg::LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            sel <= sel + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    beat && in_last |=> !in_ready)
    else $error("input still open after last byte");

  a_clr_first: assert property (@(posedge clk) disable iff (rst)
    clr_acc |-> (state == ST_REDUCE) && (sel == '0) && !acc_en)
    else $error("accumulator clear out of place");

  a_drain_adds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> acc_en && $past(sel == ioct_pkg::LAST_IDX))
    else $error("last product not accumulated");

endmodule

`default_nettype wire

FILE: sv/index_of_coincidence_tally.sv
// Top level of the index-of-coincidence tally: joins controller and datapath.
// Depends on ioct_pkg, ioct_ctrl, ioct_dp.
//
// Usage:
//   Input stream: one byte of a string per beat in s_tdata, s_tlast high on
//   the last byte. Letters A-Z/a-z are case-folded and counted; every byte
//   counts toward the length up to MAX_LEN, later bytes only set the
//   overflow flag.
//   Output stream: one beat per string, carrying sum of n(n-1) over letters,
//   L(L-1), length, non-letter count, and the overflow flag in m_tuser.
//   Throughput: one byte per cycle inside a string. After the last byte the
//   input is closed while the product unit walks the 26 letter counters,
//   one per cycle; after a drain and a finish state the result is loaded,
//   and input opens again in the same cycle as the result is presented.
//   Stall: the result sits in an output register; if it has not been taken
//   when the next result is ready, the block holds off input until it is.
//   Reset (rst, synchronous): all tallies cleared, output empty, input open.
`default_nettype none

module index_of_coincidence_tally (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [ioct_pkg::CHAR_W-1:0]         s_tdata,  // char_code[7:0]
  input  wire logic                                s_tlast,  // end_of_string
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // match_sum[17:0], pair_total[35:18], string_length[45:36],
  // nonletter_count[55:46]
  output logic [ioct_pkg::OUT_DATA_W-1:0]          m_tdata,
  output logic                                     m_tuser   // length_overflow
);

  ioct_pkg::cmd_t cmd;
  logic           out_free;

  ioct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .out_free (out_free),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  ioct_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .char_code (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_ovf   (m_tuser),
    .out_free  (out_free)
  );

endmodule

`default_nettype wire
